// ----- rtl/core/ssd_pkg.sv -----
// Shared types, codes and constants for the supply source detector.
package ssd_pkg;

  // Sample and configuration widths.
  localparam int SAMPLE_W   = 13;
  localparam int MARGIN_W   = 10;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int WINDOW_DEF = 10;

  // The debounce run counter saturates at its all-ones value.
  localparam logic [COUNT_W-1:0] RUN_MAX = '1;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] ENTER_RST  = 13'd4280;
  localparam logic [SAMPLE_W-1:0] LEAVE_RST  = 13'd4180;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;
  localparam logic [COUNT_W-1:0]  DEBOUNCE_RST = 4'd5;
  localparam logic [COUNT_W-1:0]  BOOT_RST     = 4'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER    = 3'd0,
    CFG_LEAVE    = 3'd1,
    CFG_MARGIN   = 3'd2,
    CFG_DEBOUNCE = 3'd3,
    CFG_BOOT     = 3'd4
  } cfg_idx_t;

  // Supply source and vote codes.
  typedef enum logic [1:0] {
    SRC_UNKNOWN = 2'd0,
    SRC_PLUGGED = 2'd1,
    SRC_BATTERY = 2'd2
  } src_t;

  // Per-sample classification flags handed from the window to the voter.
  typedef struct packed {
    logic plug_hit;
    logic batt_hit;
    logic full;
    logic boot_ok;
  } ssd_flags_t;

endpackage

// ----- rtl/core/ssd_cell.sv -----
// One cell of the sample window: holds a sample and passes it down the chain.
module ssd_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [ssd_pkg::SAMPLE_W-1:0] d,
  output logic [ssd_pkg::SAMPLE_W-1:0] q
);
  import ssd_pkg::*;

  // The sample moves one place towards the oldest end on every new transaction.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- rtl/core/ssd_window.sv -----
// Sample window: chain of cells, fill count, running half sums and threshold flags.
module ssd_window #(
  parameter int WINDOW = ssd_pkg::WINDOW_DEF,
  localparam int HALF  = WINDOW / 2,
  localparam int SUM_W = ssd_pkg::SAMPLE_W + $clog2(HALF)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic                         adv,
  input  logic [ssd_pkg::SAMPLE_W-1:0] sample_mv,
  input  logic [ssd_pkg::SAMPLE_W-1:0] enter_mv,
  input  logic [ssd_pkg::SAMPLE_W-1:0] leave_mv,
  input  logic [ssd_pkg::COUNT_W-1:0]  boot_min,
  output logic                         s1_valid,
  output ssd_pkg::ssd_flags_t          s1_flags,
  output logic [SUM_W-1:0]             old_sum,
  output logic [SUM_W-1:0]             new_sum
);
  import ssd_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);

  logic [SAMPLE_W-1:0] cell_q [WINDOW];
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  logic [SUM_W-1:0]    old_sum_next;
  logic [SUM_W-1:0]    new_sum_next;
  logic [SAMPLE_W-1:0] new_drop;
  logic [SAMPLE_W-1:0] old_add;
  logic [SAMPLE_W-1:0] old_drop;

  // Row of cells; the newest sample enters at the top end.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_head
      ssd_cell u_cell (.clk(clk), .shift(shift), .d(sample_mv), .q(cell_q[i]));
    end else begin : g_body
      ssd_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  // Fill count saturates once every cell holds a sample.
  assign fill_next = (fill == FILL_W'(WINDOW)) ? fill : fill + 1'b1;

  // Half sums follow the shift; a cell only counts once it has been written.
  assign new_drop = (fill >= FILL_W'(HALF)) ? cell_q[WINDOW-HALF] : '0;
  assign old_add  = (fill >= FILL_W'(WINDOW - HALF)) ? cell_q[HALF] : '0;
  assign old_drop = (fill == FILL_W'(WINDOW)) ? cell_q[0] : '0;

  assign new_sum_next = new_sum + SUM_W'(sample_mv) - SUM_W'(new_drop);
  assign old_sum_next = old_sum + SUM_W'(old_add) - SUM_W'(old_drop);

  // Fill count and half sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      old_sum <= '0;
      new_sum <= '0;
    end else if (shift) begin
      fill    <= fill_next;
      old_sum <= old_sum_next;
      new_sum <= new_sum_next;
    end
  end

  // First pipeline stage: threshold, full and boot flags of the accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= shift;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s1_flags.plug_hit <= (sample_mv >= enter_mv);
      s1_flags.batt_hit <= (sample_mv <= leave_mv);
      s1_flags.full     <= (fill_next == FILL_W'(WINDOW));
      s1_flags.boot_ok  <= (8'(fill_next) >= 8'(boot_min));
    end
  end

`ifndef SYNTHESIS
  a_fill_range : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("window fill count beyond window length");

  a_fill_hold : assert property (@(posedge clk) disable iff (rst)
    !shift |=> $stable(fill) && $stable(old_sum) && $stable(new_sum))
    else $error("window state moved without a transaction");

  a_fill_sticky : assert property (@(posedge clk) disable iff (rst)
    fill == FILL_W'(WINDOW) |=> fill == FILL_W'(WINDOW))
    else $error("full window lost its fill count");
`endif

endmodule

// ----- rtl/core/ssd_vote.sv -----
// Half means, slope vote, hysteresis vote and debounce of the supply source.
module ssd_vote #(
  parameter int WINDOW = ssd_pkg::WINDOW_DEF,
  localparam int HALF  = WINDOW / 2,
  localparam int SUM_W = ssd_pkg::SAMPLE_W + $clog2(HALF)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         s1_valid,
  input  ssd_pkg::ssd_flags_t          s1_flags,
  input  logic [SUM_W-1:0]             old_sum,
  input  logic [SUM_W-1:0]             new_sum,
  input  logic [ssd_pkg::MARGIN_W-1:0] slope_margin,
  input  logic [ssd_pkg::COUNT_W-1:0]  debounce_count,
  output logic                         out_valid,
  output ssd_pkg::src_t                src_q,
  output ssd_pkg::src_t                vote_q,
  output logic                         changed_q
);
  import ssd_pkg::*;

  // Division by HALF as a multiplication by a rounded-up reciprocal.
  localparam int RSH = SUM_W + $clog2(HALF);
  localparam logic [RSH:0] RECIP = (RSH+1)'(((64'd1 << RSH) + 64'(HALF) - 64'd1) / 64'(HALF));
  localparam int PROD_W = SUM_W + RSH + 1;

  logic                s2_valid;
  ssd_flags_t          s2_flags;
  logic [SAMPLE_W-1:0] old_mean;
  logic [SAMPLE_W-1:0] new_mean;
  logic [PROD_W-1:0]   old_prod;
  logic [PROD_W-1:0]   new_prod;
  logic signed [SAMPLE_W:0] slope;
  logic signed [SAMPLE_W:0] margin_s;
  src_t                slope_vote;
  src_t                raw_vote;
  src_t                vote_next;
  src_t                cur_src;
  src_t                cur_src_next;
  src_t                pend_vote;
  src_t                pend_vote_next;
  logic [COUNT_W-1:0]  pend_run;
  logic [COUNT_W-1:0]  pend_run_next;
  logic                changed_next;
  logic                update;

  // Second stage: truncated means of both halves.
  assign old_prod = PROD_W'(old_sum) * PROD_W'(RECIP);
  assign new_prod = PROD_W'(new_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_flags <= s1_flags;
      old_mean <= old_prod[RSH +: SAMPLE_W];
      new_mean <= new_prod[RSH +: SAMPLE_W];
    end
  end

  // Slope against the margin.
  assign slope    = $signed({1'b0, new_mean}) - $signed({1'b0, old_mean});
  assign margin_s = $signed((SAMPLE_W+1)'(slope_margin));

  always_comb begin
    priority if (slope > margin_s) begin
      slope_vote = SRC_PLUGGED;
    end else if (slope < -margin_s) begin
      slope_vote = SRC_BATTERY;
    end else begin
      slope_vote = SRC_UNKNOWN;
    end
  end

  // Thresholds first, the plugged test winning; slope only in band with a full window.
  always_comb begin
    priority if (s2_flags.plug_hit) begin
      raw_vote = SRC_PLUGGED;
    end else if (s2_flags.batt_hit) begin
      raw_vote = SRC_BATTERY;
    end else if (!s2_flags.full) begin
      raw_vote = SRC_UNKNOWN;
    end else begin
      raw_vote = slope_vote;
    end
  end

  // Debounce: track the run of agreeing votes and switch the source after enough.
  always_comb begin
    cur_src_next   = cur_src;
    pend_vote_next = pend_vote;
    pend_run_next  = pend_run;
    changed_next   = 1'b0;
    vote_next      = SRC_UNKNOWN;
    if (s2_flags.boot_ok) begin
      vote_next = raw_vote;
      if (raw_vote == SRC_UNKNOWN) begin
        pend_run_next = '0;
      end else begin
        if (raw_vote == pend_vote) begin
          pend_run_next = (pend_run == RUN_MAX) ? RUN_MAX : pend_run + 1'b1;
        end else begin
          pend_vote_next = raw_vote;
          pend_run_next  = COUNT_W'(1);
        end
        if (pend_run_next >= debounce_count && raw_vote != cur_src) begin
          cur_src_next = raw_vote;
          changed_next = 1'b1;
        end
      end
    end
  end

  assign update = adv && s2_valid;

  // Debounce state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_src   <= SRC_UNKNOWN;
      pend_vote <= SRC_UNKNOWN;
      pend_run  <= '0;
    end else if (update) begin
      cur_src   <= cur_src_next;
      pend_vote <= pend_vote_next;
      pend_run  <= pend_run_next;
    end
  end

  // Output register of the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      src_q     <= cur_src_next;
      vote_q    <= vote_next;
      changed_q <= changed_next;
    end
  end

`ifndef SYNTHESIS
  a_change_follows_vote : assert property (@(posedge clk) disable iff (rst)
    out_valid && changed_q |-> vote_q == src_q && src_q != SRC_UNKNOWN)
    else $error("source change does not match the vote");

  a_source_hold : assert property (@(posedge clk) disable iff (rst)
    !update |=> $stable(cur_src) && $stable(pend_vote) && $stable(pend_run))
    else $error("debounce state moved without a result");

  a_run_has_vote : assert property (@(posedge clk) disable iff (rst)
    pend_run != '0 |-> pend_vote != SRC_UNKNOWN)
    else $error("debounce run without a pending vote");
`endif

endmodule

// ----- rtl/core/supply_source_detector.sv -----
// Supply source detector top level: configuration registers and pipeline control.
//
// Each sample transaction yields one result transaction, offered after the flag and
// mean registers, and a new sample is taken in every cycle in which the output
// register is free or being emptied: the window is a row of WINDOW cells that shift
// once per sample, with the two half sums kept as running totals, so the only
// per-sample work is one add and subtract, one reciprocal multiply for each half
// mean and the debounce update, spread over the three pipeline stages. The whole
// pipeline holds while a finished result waits to be taken. Until WINDOW samples
// are taken, an in-band sample votes unknown. The user must write configuration
// while no transaction is in flight; the block itself does not enforce it.
module supply_source_detector #(
  parameter int WINDOW = ssd_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssd_pkg::SAMPLE_W-1:0]  sample_mv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    source,
  output logic [1:0]                    vote,
  output logic                          changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssd_pkg::SAMPLE_W-1:0]  cfg_data
);
  import ssd_pkg::*;

  localparam int HALF  = WINDOW / 2;
  localparam int SUM_W = SAMPLE_W + $clog2(HALF);

  logic [SAMPLE_W-1:0] enter_mv;
  logic [SAMPLE_W-1:0] leave_mv;
  logic [MARGIN_W-1:0] slope_margin;
  logic [COUNT_W-1:0]  debounce_count;
  logic [COUNT_W-1:0]  boot_min;
  logic                adv;
  logic                accept;
  logic                s1_valid;
  ssd_flags_t          s1_flags;
  logic [SUM_W-1:0]    old_sum;
  logic [SUM_W-1:0]    new_sum;
  src_t                src_q;
  src_t                vote_q;

  // Configuration registers; writes outside the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_mv       <= ENTER_RST;
      leave_mv       <= LEAVE_RST;
      slope_margin   <= MARGIN_RST;
      debounce_count <= DEBOUNCE_RST;
      boot_min       <= BOOT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENTER:    enter_mv       <= cfg_data;
        CFG_LEAVE:    leave_mv       <= cfg_data;
        CFG_MARGIN:   slope_margin   <= cfg_data[MARGIN_W-1:0];
        CFG_DEBOUNCE: debounce_count <= cfg_data[COUNT_W-1:0];
        CFG_BOOT:     boot_min       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or being emptied.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  ssd_window #(.WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (accept),
    .adv       (adv),
    .sample_mv (sample_mv),
    .enter_mv  (enter_mv),
    .leave_mv  (leave_mv),
    .boot_min  (boot_min),
    .s1_valid  (s1_valid),
    .s1_flags  (s1_flags),
    .old_sum   (old_sum),
    .new_sum   (new_sum)
  );

  ssd_vote #(.WINDOW(WINDOW)) u_vote (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .s1_valid       (s1_valid),
    .s1_flags       (s1_flags),
    .old_sum        (old_sum),
    .new_sum        (new_sum),
    .slope_margin   (slope_margin),
    .debounce_count (debounce_count),
    .out_valid      (out_valid),
    .src_q          (src_q),
    .vote_q         (vote_q),
    .changed_q      (changed)
  );

  assign source = src_q;
  assign vote   = vote_q;

endmodule

// ----- bench/ssd_verdict_pkg.sv -----
// Result predictor and scoreboard for the supply source detector bench.
package ssd_verdict_pkg;
  import ssd_pkg::*;

  localparam int WIN  = WINDOW_DEF;
  localparam int HALF = WIN / 2;

  // One expected result transaction.
  typedef struct {
    src_t source;
    src_t vote;
    logic changed;
  } verdict_t;

  class supply_verdict_board;
    logic [SAMPLE_W-1:0] enter_mv;
    logic [SAMPLE_W-1:0] leave_mv;
    logic [MARGIN_W-1:0] margin_mv;
    logic [COUNT_W-1:0]  debounce_len;
    logic [COUNT_W-1:0]  boot_len;

    logic [SAMPLE_W-1:0] history [WIN];
    int unsigned         fill;
    src_t                source_now;
    src_t                pending_src;
    logic [COUNT_W-1:0]  run_len;

    verdict_t            verdicts_due [$];
    int unsigned         failures;

    function new();
      enter_mv     = ENTER_RST;
      leave_mv     = LEAVE_RST;
      margin_mv    = MARGIN_RST;
      debounce_len = DEBOUNCE_RST;
      boot_len     = BOOT_RST;
      fill         = 0;
      source_now   = SRC_UNKNOWN;
      pending_src  = SRC_UNKNOWN;
      run_len      = '0;
      failures     = 0;
    endfunction

    // Mirror a configuration write; unused indexes are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        CFG_ENTER:    enter_mv     = data;
        CFG_LEAVE:    leave_mv     = data;
        CFG_MARGIN:   margin_mv    = data[MARGIN_W-1:0];
        CFG_DEBOUNCE: debounce_len = data[COUNT_W-1:0];
        CFG_BOOT:     boot_len     = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Threshold vote first, then the half-window slope once the window is full.
    function src_t classify_sample(logic [SAMPLE_W-1:0] mv);
      int old_sum;
      int new_sum;
      int slope;
      int margin;
      int i;
      old_sum = 0;
      new_sum = 0;
      if (mv >= enter_mv) return SRC_PLUGGED;
      if (mv <= leave_mv) return SRC_BATTERY;
      if (fill < WIN) return SRC_UNKNOWN;
      for (i = 0; i < HALF; i++) begin
        old_sum += history[i];
        new_sum += history[WIN - HALF + i];
      end
      slope  = new_sum / HALF - old_sum / HALF;
      margin = margin_mv;
      if (slope > margin) return SRC_PLUGGED;
      if (slope < -margin) return SRC_BATTERY;
      return SRC_UNKNOWN;
    endfunction

    // Note an accepted sample transaction and queue the result it must give.
    function void take_sample(logic [SAMPLE_W-1:0] mv);
      verdict_t v;
      int       i;
      if (fill < WIN) begin
        history[fill] = mv;
        fill++;
      end else begin
        for (i = 0; i < WIN - 1; i++) history[i] = history[i + 1];
        history[WIN - 1] = mv;
      end
      v.vote    = SRC_UNKNOWN;
      v.changed = 1'b0;
      // No vote is taken during the boot period.
      if (fill >= boot_len) begin
        v.vote = classify_sample(mv);
        if (v.vote == SRC_UNKNOWN) begin
          run_len = '0;
        end else begin
          if (v.vote == pending_src) begin
            if (run_len != RUN_MAX) run_len++;
          end else begin
            pending_src = v.vote;
            run_len     = COUNT_W'(1);
          end
          if (run_len >= debounce_len && v.vote != source_now) begin
            source_now = v.vote;
            v.changed  = 1'b1;
          end
        end
      end
      v.source = source_now;
      verdicts_due.push_back(v);
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic [1:0] source, logic [1:0] vote, logic changed);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("result transaction with no sample outstanding: source %0d vote %0d changed %0d",
               source, vote, changed);
        failures++;
        return;
      end
      v = verdicts_due.pop_front();
      if (source !== v.source) begin
        $error("source: expected %0d, actual %0d", v.source, source);
        failures++;
      end
      if (vote !== v.vote) begin
        $error("vote: expected %0d, actual %0d", v.vote, vote);
        failures++;
      end
      if (changed !== v.changed) begin
        $error("changed: expected %0d, actual %0d", v.changed, changed);
        failures++;
      end
    endfunction
  endclass

endpackage

// ----- bench/tb.sv -----
// Top-level bench for the supply source detector: stimulus, flow control and checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;
  import ssd_verdict_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int PIPE_SETTLE     = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 14;
  localparam int PHASE_ITEMS     = 100;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam int MARGIN_MAX      = (1 << MARGIN_W) - 1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample_mv;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           source;
  logic [1:0]           vote;
  logic                 changed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;

  supply_verdict_board board = new();
  int unsigned         cycles_run = 0;
  int                  burst_left;
  bit                  hold_off_request;

  supply_source_detector uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_mv (sample_mv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .source    (source),
    .vote      (vote),
    .changed   (changed),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) cycles_run <= cycles_run + 1;

  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Every accepted result transaction is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(source, vote, changed);
  end

  // Receiver: stalls on patterns of its own, with an occasional long hold-off.
  initial begin : receiver
    int          style;
    int          stretch_left;
    int unsigned tick;
    style        = 0;
    stretch_left = 0;
    tick         = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          style        = $urandom_range(0, 3);
          stretch_left = $urandom_range(16, 160);
        end
        stretch_left--;
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  function automatic int clamp_mv(int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  // Occasionally set bits above a narrow register's width; they must be ignored.
  function automatic logic [SAMPLE_W-1:0] with_junk(int value, int width);
    logic [SAMPLE_W-1:0] data;
    data = SAMPLE_W'(value);
    if ($urandom_range(0, 3) == 0) data = data | SAMPLE_W'($urandom() << width);
    return data;
  endfunction

  // Offer one sample transaction and hold it until it is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
    in_valid  <= 1'b1;
    sample_mv <= mv;
    do @(posedge clk); while (!in_ready);
    board.take_sample(mv);
  endtask

  // Sender in bursts of random length with random gaps between them.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] mv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    send_sample(mv);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // One configuration transaction; the caller lowers cfg_valid after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // Write all registers: fixed extremes for the first phases, random afterwards.
  task automatic configure_phase(input int phase);
    int enter_v;
    int leave_v;
    int margin_v;
    int debounce_v;
    int boot_v;
    int pick;
    case (phase)
      0: begin
        enter_v = 0; leave_v = 0; margin_v = 0; debounce_v = 1; boot_v = 1;
      end
      1: begin
        enter_v = SAMPLE_MAX; leave_v = 0; margin_v = MARGIN_MAX;
        debounce_v = RUN_MAX; boot_v = WIN;
      end
      2: begin
        enter_v = SAMPLE_MAX; leave_v = 0; margin_v = 0; debounce_v = 1; boot_v = WIN;
      end
      3: begin
        enter_v = SAMPLE_MAX; leave_v = SAMPLE_MAX; margin_v = 0;
        debounce_v = 2; boot_v = 3;
      end
      default: begin
        pick = $urandom_range(0, 9);
        if (pick < 6) enter_v = int'(ENTER_RST) - 200 + int'($urandom_range(0, 400));
        else if (pick < 8) enter_v = $urandom_range(0, SAMPLE_MAX);
        else if (pick == 8) enter_v = 0;
        else enter_v = SAMPLE_MAX;
        pick = $urandom_range(0, 9);
        if (pick < 7) leave_v = enter_v - int'($urandom_range(1, 300));
        else if (pick < 8) leave_v = enter_v + int'($urandom_range(0, 300));
        else leave_v = $urandom_range(0, SAMPLE_MAX);
        pick = $urandom_range(0, 9);
        if (pick < 6) margin_v = $urandom_range(0, 60);
        else if (pick < 8) margin_v = $urandom_range(0, MARGIN_MAX);
        else if (pick == 8) margin_v = 0;
        else margin_v = MARGIN_MAX;
        debounce_v = $urandom_range(0, RUN_MAX);
        boot_v = ($urandom_range(0, 9) == 0) ? $urandom_range(WIN + 1, RUN_MAX)
                                             : $urandom_range(0, WIN);
      end
    endcase
    write_reg(CFG_ENTER, SAMPLE_W'(clamp_mv(enter_v)));
    write_reg(CFG_LEAVE, SAMPLE_W'(clamp_mv(leave_v)));
    write_reg(CFG_MARGIN, with_junk(margin_v, MARGIN_W));
    write_reg(CFG_DEBOUNCE, with_junk(debounce_v, COUNT_W));
    write_reg(CFG_BOOT, with_junk(boot_v, COUNT_W));
    cfg_valid <= 1'b0;
  endtask

  // Segments of ramps, threshold dithering, plateaus and noise around the band.
  task automatic run_random_phase(input int count);
    int enter_v;
    int leave_v;
    int band_lo;
    int band_hi;
    int level;
    int style;
    int seg_left;
    int step;
    int i;
    enter_v  = board.enter_mv;
    leave_v  = board.leave_mv;
    band_lo  = clamp_mv(leave_v + 1);
    band_hi  = clamp_mv(enter_v - 1);
    if (band_hi < band_lo) begin
      band_lo = enter_v;
      band_hi = enter_v;
    end
    seg_left = 0;
    style    = 0;
    step     = 0;
    level    = band_lo;
    for (i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        style    = $urandom_range(0, 9);
        seg_left = $urandom_range(4, 30);
        step     = $urandom_range(0, 40);
        case (style)
          2, 3: level = band_lo;
          4, 5: level = band_hi;
          6:    level = enter_v;
          7:    level = leave_v;
          default: level = (band_lo + band_hi) / 2;
        endcase
      end
      seg_left--;
      case (style)
        0: level = $urandom_range(0, SAMPLE_MAX);
        1: level = $urandom_range(0, 1) ? SAMPLE_MAX - int'($urandom_range(0, 3))
                                        : int'($urandom_range(0, 3));
        2, 3: level = level + step;
        4, 5: level = level - step;
        6, 7: level = level + int'($urandom_range(0, 16)) - 8;
        8: level = (band_lo + band_hi) / 2 + int'($urandom_range(0, 6)) - 3;
        default: level = $urandom_range(band_lo, band_hi);
      endcase
      level = clamp_mv(level);
      offer_sample(level[SAMPLE_W-1:0]);
    end
  endtask

  // Main sequence.
  initial begin
    int k;
    int p;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample_mv <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ENTER;
    cfg_data  <= '0;
    burst_left       = 0;
    hold_off_request = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero boot minimum lets the very first sample vote; zero debounce acts as one.
    write_reg(CFG_BOOT, '0);
    write_reg(CFG_DEBOUNCE, '0);
    cfg_valid <= 1'b0;

    // Field extremes and both thresholds, then a rising and a falling in-band ramp.
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample('0);
    send_sample(ENTER_RST);
    send_sample(ENTER_RST - 1'b1);
    send_sample(LEAVE_RST);
    send_sample(LEAVE_RST + 1'b1);
    for (k = 0; k < 9; k++) send_sample(SAMPLE_W'(int'(LEAVE_RST) + 10 + 10 * k));
    for (k = 0; k < 5; k++) send_sample(SAMPLE_W'(int'(LEAVE_RST) + 90 - 20 * k));
    drain_results();

    // Writes to unused indexes must leave every register alone.
    for (k = CFG_BOOT + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), SAMPLE_W'($urandom()));
    end
    // Overlapping thresholds, and a boot minimum beyond the window.
    write_reg(CFG_ENTER, 13'd4000);
    write_reg(CFG_LEAVE, 13'd4500);
    write_reg(CFG_MARGIN, SAMPLE_W'(MARGIN_MAX));
    write_reg(CFG_DEBOUNCE, SAMPLE_W'(RUN_MAX));
    write_reg(CFG_BOOT, SAMPLE_W'(WIN + 1));
    cfg_valid <= 1'b0;
    send_sample(13'd4200);
    send_sample(13'd3000);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain_results();

    // Random phases, each under a fresh configuration written while idle.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      configure_phase(p);
      if (p == 5) begin
        // Receiver holds off while the sender keeps offering, so the input stalls.
        hold_off_request = 1'b1;
        burst_left       = 60;
        run_random_phase(60);
      end
      run_random_phase(PHASE_ITEMS);
      drain_results();
    end

    if (board.failures == 0 && board.verdicts_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
